[hdl/domain_lifecycle_restart_fsm_macros.svh]
// Assertion macros for the domain lifecycle restart block.
// Used by the top level; expects clk and rst in scope.
`ifndef DOMAIN_LIFECYCLE_RESTART_FSM_MACROS_SVH
`define DOMAIN_LIFECYCLE_RESTART_FSM_MACROS_SVH

// same-cycle implication
`define DLR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlr assertion failed (same cycle)");

// next-cycle implication
`define DLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlr assertion failed (next cycle)");

`endif

[hdl/dlr_pkg.sv]
// Shared types, codes and helpers for the domain lifecycle restart block.
// No dependencies.
package dlr_pkg;

  localparam logic [2:0] EV_INIT    = 3'd0;
  localparam logic [2:0] EV_START   = 3'd1;
  localparam logic [2:0] EV_WAIT    = 3'd2;
  localparam logic [2:0] EV_SIGNAL  = 3'd3;
  localparam logic [2:0] EV_PREEMPT = 3'd4;
  localparam logic [2:0] EV_PANIC   = 3'd5;
  localparam logic [2:0] EV_RESTART = 3'd6;
  localparam logic [2:0] EV_STOP    = 3'd7;

  localparam logic [1:0] RC_OK       = 2'd0;
  localparam logic [1:0] RC_POLICY   = 2'd1;
  localparam logic [1:0] RC_ILLEGAL  = 2'd2;
  localparam logic [1:0] RC_TERMINAL = 2'd3;

  localparam logic [2:0] DS_STOPPED    = 3'd0;
  localparam logic [2:0] DS_READY      = 3'd1;
  localparam logic [2:0] DS_RUNNING    = 3'd2;
  localparam logic [2:0] DS_BLOCKED    = 3'd3;
  localparam logic [2:0] DS_FAULTED    = 3'd4;
  localparam logic [2:0] DS_RESTARTING = 3'd5;

  localparam logic [1:0] ACT_FAULT    = 2'd0;
  localparam logic [1:0] ACT_DOMAIN   = 2'd1;
  localparam logic [1:0] ACT_PLATFORM = 2'd2;

  localparam logic [1:0] CFG_ACTION = 2'd0;
  localparam logic [1:0] CFG_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_WINDOW = 2'd2;

  typedef enum logic [5:0] {
    LC_STOPPED    = 6'b000001,
    LC_READY      = 6'b000010,
    LC_RUNNING    = 6'b000100,
    LC_BLOCKED    = 6'b001000,
    LC_FAULTED    = 6'b010000,
    LC_RESTARTING = 6'b100000
  } lc_state_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [31:0] tick_now;
  } dlr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  domain_state;
    logic [31:0] restarts_used;
  } dlr_out_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] limit;
    logic [31:0] window;
  } dlr_policy_t;

  typedef struct packed {
    lc_state_t   lstate;
    logic [31:0] count;
    logic [31:0] win_start;
  } dlr_ctx_t;

  function automatic logic policy_valid(dlr_policy_t p);
    logic ok;
    if (p.action == ACT_DOMAIN) begin
      ok = (p.limit != '0) && (p.window != '0);
    end else if (p.action == ACT_FAULT || p.action == ACT_PLATFORM) begin
      ok = (p.limit == '0) && (p.window == '0);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [2:0] state_code(lc_state_t s);
    logic [2:0] c;
    case (s)
      LC_STOPPED:    c = DS_STOPPED;
      LC_READY:      c = DS_READY;
      LC_RUNNING:    c = DS_RUNNING;
      LC_BLOCKED:    c = DS_BLOCKED;
      LC_FAULTED:    c = DS_FAULTED;
      LC_RESTARTING: c = DS_RESTARTING;
      default:       c = DS_STOPPED;
    endcase
    return c;
  endfunction

endpackage

[hdl/domain_lifecycle_restart_fsm.sv]
// Domain lifecycle state machine with a windowed restart budget on panic.
// Depends on dlr_pkg, dlr_step and domain_lifecycle_restart_fsm_macros.svh.
//
// Channels: event_* carries one event word (event_code, tick_now); result_*
// returns one word per event (status, domain_state, restarts_used); cfg_*
// writes the policy registers (index 0 action, 1 limit, 2 window) and is
// always ready. Writes to index 3 are taken and ignored.
// An accepted event goes through the event register and then the result
// register to result_data. Throughput: one event per cycle while result_ready
// holds. The event register feeds the state update and the result register
// in one step, so state is current for the next event with no bubble.
// Stall: while result_valid waits for result_ready, one more event may sit
// in the event register; event_ready then drops until the result drains.
// Reset: synchronous rst clears the valid flags, the policy registers, the
// lifecycle state to stopped, the restart count and the window start tick.
// An inconsistent policy answers every event with a policy-invalid status.
`include "domain_lifecycle_restart_fsm_macros.svh"

module domain_lifecycle_restart_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              event_valid,
  output logic              event_ready,
  input  dlr_pkg::dlr_in_t  event_data,
  output logic              result_valid,
  input  logic              result_ready,
  output dlr_pkg::dlr_out_t result_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  dlr_pkg::dlr_policy_t policy;
  dlr_pkg::dlr_ctx_t    ctx;
  dlr_pkg::dlr_ctx_t    ctx_next;
  dlr_pkg::dlr_in_t     in_word;
  dlr_pkg::dlr_out_t    res_next;
  logic                 in_vld;
  logic                 advance;

  assign advance     = in_vld && (!result_valid || result_ready);
  assign event_ready = !in_vld || advance;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dlr_pkg::CFG_ACTION: policy.action <= cfg_data[1:0];
        dlr_pkg::CFG_LIMIT:  policy.limit  <= cfg_data;
        dlr_pkg::CFG_WINDOW: policy.window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (event_ready) begin
      in_vld <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_ready && event_valid) in_word <= event_data;
  end

  dlr_step u_step (
    .policy (policy),
    .cur    (ctx),
    .evt    (in_word),
    .nxt    (ctx_next),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.lstate    <= dlr_pkg::LC_STOPPED;
      ctx.count     <= '0;
      ctx.win_start <= '0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result_data <= res_next;
  end

  `DLR_ASSERT_NEXT(a_policy_hold, advance && !dlr_pkg::policy_valid(policy), ctx == $past(ctx))
  `DLR_ASSERT_NEXT(a_count_panic_only, advance && in_word.event_code != dlr_pkg::EV_PANIC, $stable(ctx.count))
  `DLR_ASSERT_NOW(a_terminal_faults, result_valid && result_data.status == dlr_pkg::RC_TERMINAL, result_data.domain_state == dlr_pkg::DS_FAULTED)
  `DLR_ASSERT_NOW(a_restart_counted, result_valid && result_data.domain_state == dlr_pkg::DS_RESTARTING, result_data.restarts_used != '0)

endmodule

[hdl/dlr_step.sv]
// Next-state and result logic for one lifecycle event.
// Depends on dlr_pkg.
module dlr_step (
  input  dlr_pkg::dlr_policy_t policy,
  input  dlr_pkg::dlr_ctx_t    cur,
  input  dlr_pkg::dlr_in_t     evt,
  output dlr_pkg::dlr_ctx_t    nxt,
  output dlr_pkg::dlr_out_t    res
);

  logic [31:0] diff;
  logic        expired;
  logic [31:0] cnt0;
  logic [31:0] ws0;
  logic        spent;
  logic [1:0]  status;

  assign diff    = evt.tick_now - cur.win_start;
  assign expired = (cur.count == '0) || (diff >= policy.window);
  assign cnt0    = expired ? '0 : cur.count;
  assign ws0     = expired ? evt.tick_now : cur.win_start;
  assign spent   = (cnt0 >= policy.limit) || (&cnt0);

  always_comb begin
    nxt    = cur;
    status = dlr_pkg::RC_OK;
    if (!dlr_pkg::policy_valid(policy)) begin
      status = dlr_pkg::RC_POLICY;
    end else begin
      case (evt.event_code)
        dlr_pkg::EV_INIT: begin
          if (cur.lstate == dlr_pkg::LC_STOPPED) nxt.lstate = dlr_pkg::LC_READY;
          else status = dlr_pkg::RC_ILLEGAL;
        end
        dlr_pkg::EV_START: begin
          if (cur.lstate == dlr_pkg::LC_READY) nxt.lstate = dlr_pkg::LC_RUNNING;
          else status = dlr_pkg::RC_ILLEGAL;
        end
        dlr_pkg::EV_WAIT: begin
          if (cur.lstate == dlr_pkg::LC_RUNNING) nxt.lstate = dlr_pkg::LC_BLOCKED;
          else status = dlr_pkg::RC_ILLEGAL;
        end
        dlr_pkg::EV_SIGNAL: begin
          if (cur.lstate == dlr_pkg::LC_BLOCKED) nxt.lstate = dlr_pkg::LC_READY;
          else status = dlr_pkg::RC_ILLEGAL;
        end
        dlr_pkg::EV_PREEMPT: begin
          if (cur.lstate == dlr_pkg::LC_RUNNING) nxt.lstate = dlr_pkg::LC_READY;
          else status = dlr_pkg::RC_ILLEGAL;
        end
        dlr_pkg::EV_PANIC: begin
          if (cur.lstate == dlr_pkg::LC_STOPPED || cur.lstate == dlr_pkg::LC_FAULTED) begin
            status = dlr_pkg::RC_ILLEGAL;
          end else if (policy.action != dlr_pkg::ACT_DOMAIN) begin
            nxt.lstate = dlr_pkg::LC_FAULTED;
            status     = dlr_pkg::RC_TERMINAL;
          end else begin
            // window refresh sticks even if the budget is spent
            nxt.count     = cnt0;
            nxt.win_start = ws0;
            if (spent) begin
              nxt.lstate = dlr_pkg::LC_FAULTED;
              status     = dlr_pkg::RC_TERMINAL;
            end else begin
              nxt.count  = cnt0 + 32'd1;
              if (cnt0 == '0) nxt.win_start = evt.tick_now;
              nxt.lstate = dlr_pkg::LC_RESTARTING;
            end
          end
        end
        dlr_pkg::EV_RESTART: begin
          if (cur.lstate == dlr_pkg::LC_RESTARTING) nxt.lstate = dlr_pkg::LC_READY;
          else status = dlr_pkg::RC_ILLEGAL;
        end
        dlr_pkg::EV_STOP: begin
          if (cur.lstate == dlr_pkg::LC_STOPPED) status = dlr_pkg::RC_ILLEGAL;
          else nxt.lstate = dlr_pkg::LC_STOPPED;
        end
        default: begin
          status = dlr_pkg::RC_ILLEGAL;
        end
      endcase
    end
  end

  assign res.status        = status;
  assign res.domain_state  = dlr_pkg::state_code(nxt.lstate);
  assign res.restarts_used = nxt.count;

endmodule
